>>> rtl/core/mchtu_pkg.sv
// Shared types and codes for the monotone convex hull trick unit.
package mchtu_pkg;

   localparam logic [2:0] FUNC_ADD   = 3'd0;
   localparam logic [2:0] FUNC_QUERY = 3'd1;
   localparam logic [2:0] FUNC_INC   = 3'd2;
   localparam logic [2:0] FUNC_DEC   = 3'd3;
   localparam logic [2:0] FUNC_CLEAR = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_ORDER = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic signed [31:0] slope;
      logic signed [31:0] intercept;
   } line_type;

endpackage

>>> rtl/core/mchtu_line_ram.sv
// Line store: one write port and one registered read port.
module mchtu_line_ram import mchtu_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int AW = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  line_type      wr_line,
   input  logic [AW-1:0] rd_addr,
   output line_type      rd_line
);

   line_type mem [DEPTH];
   line_type rd_line_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_line;
      end
      rd_line_ff <= mem[rd_addr];
   end

   assign rd_line = rd_line_ff;

endmodule

>>> rtl/core/monotone_convex_hull_trick_unit.sv
// Top level of the monotone convex hull trick unit.
//
// Usage: the req_ channel carries one transaction per operation: add a line,
// query the envelope at req_x_point (plain, increasing or decreasing), or
// clear. Every transaction yields exactly one rsp_ transaction with a value
// and a status. csr_we writes the minimize mode; write it only when idle.
// The unit works on one transaction at a time; req_ready is high only while
// no operation is in progress. The work per transaction, with the RAM reads
// and the one shared multiplier used in turn:
//   clear, unused code, empty query, add to an empty hull: no further steps.
//   add rejected for order or full, or an equal slope that is kept: the
//   front and back lines are read and compared. Other add: the same reads,
//   a dominance test while two or more lines remain, a pop per line covered.
//   plain query: a search (about log2 of the line count steps), a final read;
//   increasing or decreasing query: a comparison per popped line, then a
//   final read when one line is left at the end, else a last comparison.
// A finished result sits in the output register; a new transaction may be
// taken while it waits. The unit stalls in its final step only if the
// previous result has not yet been taken. Reset empties the hull, sets
// minimize mode and drops any pending result; the RAM needs no clearing.
module monotone_convex_hull_trick_unit import mchtu_pkg::*; #(
   parameter int HULL_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_func,
   input  logic signed [31:0] req_slope,
   input  logic signed [31:0] req_intercept,
   input  logic signed [31:0] req_x_point,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [62:0] rsp_value,
   output logic [1:0]         rsp_status,
   input  logic               csr_we,
   input  logic [0:0]         csr_wdata
);

   localparam int IW = (HULL_DEPTH > 1) ? $clog2(HULL_DEPTH) : 1;
   localparam int CW = $clog2(HULL_DEPTH + 1);
   localparam logic [CW:0] DEPTH_W = (CW + 1)'(HULL_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(HULL_DEPTH);
   localparam logic [IW-1:0] LAST_SLOT = IW'(HULL_DEPTH - 1);
   localparam logic signed [65:0] VAL_MAX = (66'sd1 <<< 62) - 66'sd1;
   localparam logic signed [65:0] VAL_MIN = -(66'sd1 <<< 62);

   typedef enum logic [4:0] {
      S_IDLE, S_A_RDF, S_A_RDB, S_A_DEC, S_L_TOP, S_L_RDN, S_L_RDF, S_L_CAP,
      S_L_M1, S_L_M2, S_L_CMP, S_PUSH, S_Q_TOP, S_Q_RDP, S_Q_RDQ, S_Q_CAPQ,
      S_Q_CMP, S_Q_FRD, S_Q_FCAP, S_Q_FSUM, S_DONE
   } state_type;

   state_type state_ff;
   logic [2:0] func_ff;
   logic signed [31:0] na_ff, nb_ff, x_ff, pa_ff, pb_ff, qa_ff, qb_ff;
   logic [IW-1:0] head_ff;
   logic [CW-1:0] count_ff, poff_ff, qoff_ff, fin_off_ff;
   logic mode_ff, front_ff, res_q_ff, rsp_valid_ff;
   logic signed [CW:0] lo_ff, hi_ff;
   logic signed [65:0] prod_ff, pq_ff;
   logic signed [64:0] yp_ff, y_ff;
   logic [1:0] res_status_ff, rsp_status_ff;
   logic signed [62:0] rsp_value_ff;

   logic [CW-1:0] rd_off;
   logic [CW:0] rd_sum, wr_sum;
   logic [IW-1:0] rd_addr, wr_addr, head_inc, head_dec;
   logic wr_en;
   line_type wr_line, mem_q;
   logic signed [32:0] mul_a, mul_b;
   logic signed [32:0] a1, b1, a2, b2, a3, b3, dp, dq, dr, ds;
   logic dom, ge;
   logic signed [CW:0] mid;
   logic [CW-1:0] mid_off, cnt_m1, cnt_m2;
   logic signed [64:0] yq, yfin;
   logic signed [65:0] yv;
   logic signed [62:0] fin_value;
   logic signed [31:0] neg_a, neg_b;
   logic rsp_load;

   function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
      logic signed [31:0] r;
      r = (v == 32'sh8000_0000) ? 32'sh7fff_ffff : -v;
      return r;
   endfunction

   function automatic logic signed [1:0] sgn_mul(input logic signed [32:0] u,
                                                 input logic signed [32:0] v);
      logic signed [1:0] r;
      if (u == 33'sd0 || v == 33'sd0) begin
         r = 2'sd0;
      end else if (u[32] ^ v[32]) begin
         r = -2'sd1;
      end else begin
         r = 2'sd1;
      end
      return r;
   endfunction

   assign cnt_m1 = count_ff - CW'(1);
   assign cnt_m2 = count_ff - CW'(2);
   assign head_inc = (head_ff == LAST_SLOT) ? '0 : head_ff + IW'(1);
   assign head_dec = (head_ff == '0) ? LAST_SLOT : head_ff - IW'(1);
   assign mid = lo_ff + ((hi_ff - lo_ff) >>> 1);
   assign mid_off = mid[CW-1:0];

   always_comb begin
      case (state_ff)
         S_A_RDF: rd_off = '0;
         S_A_RDB: rd_off = cnt_m1;
         S_L_RDN: rd_off = front_ff ? '0 : cnt_m1;
         S_L_RDF: rd_off = front_ff ? CW'(1) : cnt_m2;
         S_Q_RDP: rd_off = poff_ff;
         S_Q_RDQ: rd_off = qoff_ff;
         S_Q_FRD: rd_off = fin_off_ff;
         default: rd_off = '0;
      endcase
   end

   assign rd_sum = (CW + 1)'(head_ff) + (CW + 1)'(rd_off);
   assign rd_addr = IW'((rd_sum >= DEPTH_W) ? rd_sum - DEPTH_W : rd_sum);
   assign wr_sum = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
   assign wr_en = (state_ff == S_PUSH) ||
                  (state_ff == S_IDLE && req_valid && req_func == FUNC_ADD &&
                   count_ff == '0);
   assign wr_addr = (state_ff == S_IDLE || front_ff) ? head_dec :
                    IW'((wr_sum >= DEPTH_W) ? wr_sum - DEPTH_W : wr_sum);
   assign neg_a = mode_ff ? req_slope : neg_sat(req_slope);
   assign neg_b = mode_ff ? req_intercept : neg_sat(req_intercept);
   assign wr_line = (state_ff == S_IDLE) ? line_type'{slope: neg_a, intercept: neg_b}
                                         : line_type'{slope: na_ff, intercept: nb_ff};

   mchtu_line_ram #(
      .DEPTH (HULL_DEPTH),
      .AW    (IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_line (wr_line),
      .rd_addr (rd_addr),
      .rd_line (mem_q)
   );

   always_comb begin
      if (front_ff) begin
         a1 = 33'(na_ff); b1 = 33'(nb_ff); a3 = 33'(qa_ff); b3 = 33'(qb_ff);
      end else begin
         a1 = 33'(qa_ff); b1 = 33'(qb_ff); a3 = 33'(na_ff); b3 = 33'(nb_ff);
      end
      a2 = 33'(pa_ff);
      b2 = 33'(pb_ff);
      dp = a2 - a1;
      dq = b3 - b2;
      dr = b2 - b1;
      ds = a3 - a2;
      if (b2 == b1 || b3 == b2) begin
         dom = sgn_mul(dp, dq) >= sgn_mul(ds, dr);
      end else begin
         dom = pq_ff >= prod_ff;
      end
   end

   always_comb begin
      case (state_ff)
         S_Q_RDQ, S_Q_CAPQ, S_Q_FCAP: begin
            mul_a = 33'(mem_q.slope);
            mul_b = 33'(x_ff);
         end
         S_L_M1: begin
            mul_a = dp;
            mul_b = dq;
         end
         S_L_M2: begin
            mul_a = dr;
            mul_b = ds;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign yq = prod_ff[64:0] + 65'(qb_ff);
   assign ge = yp_ff >= yq;
   assign yfin = prod_ff[64:0] + 65'(pb_ff);
   assign yv = mode_ff ? 66'(y_ff) : -66'(y_ff);
   assign fin_value = (yv > VAL_MAX) ? VAL_MAX[62:0] :
                      (yv < VAL_MIN) ? VAL_MIN[62:0] : yv[62:0];
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= '0;
         count_ff <= '0;
         mode_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         prod_ff <= mul_a * mul_b;
         if (csr_we) begin
            mode_ff <= csr_wdata[0];
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  func_ff <= req_func;
                  na_ff <= neg_a;
                  nb_ff <= neg_b;
                  x_ff <= req_x_point;
                  res_q_ff <= 1'b0;
                  res_status_ff <= ST_OK;
                  lo_ff <= '1;
                  hi_ff <= $signed({1'b0, count_ff}) - (CW + 1)'(1);
                  state_ff <= S_DONE;
                  case (req_func)
                     FUNC_ADD: begin
                        if (count_ff == '0) begin
                           head_ff <= head_dec;
                           count_ff <= CW'(1);
                        end else begin
                           state_ff <= S_A_RDF;
                        end
                     end
                     FUNC_QUERY, FUNC_INC, FUNC_DEC: begin
                        if (count_ff == '0) begin
                           res_status_ff <= ST_EMPTY;
                        end else begin
                           state_ff <= S_Q_TOP;
                        end
                     end
                     FUNC_CLEAR: begin
                        head_ff <= '0;
                        count_ff <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            S_A_RDF: state_ff <= S_A_RDB;
            S_A_RDB: begin
               pa_ff <= mem_q.slope;
               pb_ff <= mem_q.intercept;
               state_ff <= S_A_DEC;
            end
            S_A_DEC: begin
               if (!(na_ff <= mem_q.slope || na_ff >= pa_ff)) begin
                  res_status_ff <= ST_ORDER;
                  state_ff <= S_DONE;
               end else if (pa_ff <= na_ff) begin
                  front_ff <= 1'b1;
                  if (pa_ff == na_ff && pb_ff <= nb_ff) begin
                     state_ff <= S_DONE;
                  end else if (pa_ff == na_ff) begin
                     head_ff <= head_inc;
                     count_ff <= cnt_m1;
                     state_ff <= S_L_TOP;
                  end else if (count_ff == DEPTH_C) begin
                     res_status_ff <= ST_FULL;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_L_TOP;
                  end
               end else begin
                  front_ff <= 1'b0;
                  if (mem_q.slope == na_ff && mem_q.intercept <= nb_ff) begin
                     state_ff <= S_DONE;
                  end else if (mem_q.slope == na_ff) begin
                     count_ff <= cnt_m1;
                     state_ff <= S_L_TOP;
                  end else if (count_ff == DEPTH_C) begin
                     res_status_ff <= ST_FULL;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_L_TOP;
                  end
               end
            end
            S_L_TOP: state_ff <= (count_ff >= CW'(2)) ? S_L_RDN : S_PUSH;
            S_L_RDN: state_ff <= S_L_RDF;
            S_L_RDF: begin
               pa_ff <= mem_q.slope;
               pb_ff <= mem_q.intercept;
               state_ff <= S_L_CAP;
            end
            S_L_CAP: begin
               qa_ff <= mem_q.slope;
               qb_ff <= mem_q.intercept;
               state_ff <= S_L_M1;
            end
            S_L_M1: state_ff <= S_L_M2;
            S_L_M2: begin
               pq_ff <= prod_ff;
               state_ff <= S_L_CMP;
            end
            S_L_CMP: begin
               if (dom) begin
                  if (front_ff) begin
                     head_ff <= head_inc;
                  end
                  count_ff <= cnt_m1;
                  state_ff <= S_L_TOP;
               end else begin
                  state_ff <= S_PUSH;
               end
            end
            S_PUSH: begin
               if (front_ff) begin
                  head_ff <= head_dec;
               end
               count_ff <= count_ff + CW'(1);
               state_ff <= S_DONE;
            end
            S_Q_TOP: begin
               state_ff <= S_Q_FRD;
               case (func_ff)
                  FUNC_QUERY: begin
                     fin_off_ff <= hi_ff[CW-1:0];
                     if (lo_ff + (CW + 1)'(1) < hi_ff) begin
                        poff_ff <= mid_off;
                        qoff_ff <= mid_off + CW'(1);
                        state_ff <= S_Q_RDP;
                     end
                  end
                  FUNC_INC: begin
                     fin_off_ff <= '0;
                     poff_ff <= '0;
                     qoff_ff <= CW'(1);
                     if (count_ff >= CW'(2)) begin
                        state_ff <= S_Q_RDP;
                     end
                  end
                  default: begin
                     fin_off_ff <= cnt_m1;
                     poff_ff <= cnt_m1;
                     qoff_ff <= cnt_m2;
                     if (count_ff >= CW'(2)) begin
                        state_ff <= S_Q_RDP;
                     end
                  end
               endcase
            end
            S_Q_RDP: state_ff <= S_Q_RDQ;
            S_Q_RDQ: begin
               pa_ff <= mem_q.slope;
               pb_ff <= mem_q.intercept;
               state_ff <= S_Q_CAPQ;
            end
            S_Q_CAPQ: begin
               yp_ff <= yfin;
               qa_ff <= mem_q.slope;
               qb_ff <= mem_q.intercept;
               state_ff <= S_Q_CMP;
            end
            S_Q_CMP: begin
               state_ff <= S_Q_TOP;
               if (func_ff == FUNC_QUERY) begin
                  if (ge) begin
                     lo_ff <= mid;
                  end else begin
                     hi_ff <= mid;
                  end
               end else if (ge) begin
                  if (func_ff == FUNC_INC) begin
                     head_ff <= head_inc;
                  end
                  count_ff <= cnt_m1;
               end else begin
                  y_ff <= yp_ff;
                  res_q_ff <= 1'b1;
                  state_ff <= S_DONE;
               end
            end
            S_Q_FRD: state_ff <= S_Q_FCAP;
            S_Q_FCAP: begin
               pa_ff <= mem_q.slope;
               pb_ff <= mem_q.intercept;
               state_ff <= S_Q_FSUM;
            end
            S_Q_FSUM: begin
               y_ff <= yfin;
               res_q_ff <= 1'b1;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_value_ff <= res_q_ff ? fin_value : '0;
                  rsp_status_ff <= res_status_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

>>> rtl/core/mchtu_checker.sv
// Port-level assertions for the monotone convex hull trick unit, with its bind.
module mchtu_checker import mchtu_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [62:0] rsp_value,
   input logic [1:0]         rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("Result changed while stalled.");

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid right after reset.");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_value == '0)
      else $error("Nonzero value with an error status.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Unit ready in the cycle after a transaction.");

endmodule

bind monotone_convex_hull_trick_unit mchtu_checker u_mchtu_checker (.*);

>>> tb/mchtu_checker.sv
// Checker for the hull unit: predicts every response and compares it with the observed one.
`timescale 1ns / 100ps
module mchtu_scoreboard import mchtu_pkg::*; #(
   parameter int HULL_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_func,
   input  logic signed [31:0] req_slope,
   input  logic signed [31:0] req_intercept,
   input  logic signed [31:0] req_x_point,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [62:0] rsp_value,
   input  logic [1:0]         rsp_status,
   input  logic               csr_we,
   input  logic [0:0]         csr_wdata,
   output int                 fail_count,
   output int                 pending_count
);

   typedef struct {
      logic signed [62:0] value;
      logic [1:0]         status;
   } outcome_type;

   line_type    hull_lines [HULL_DEPTH];
   int          front_pos;
   int          line_total;
   logic        minimize;
   outcome_type expected_outcomes [$];

   function automatic int slot_of(int i);
      return (front_pos + i) % HULL_DEPTH;
   endfunction

   function automatic longint slope_at(int i);
      return longint'(hull_lines[slot_of(i)].slope);
   endfunction

   function automatic longint icpt_at(int i);
      return longint'(hull_lines[slot_of(i)].intercept);
   endfunction

   function automatic longint eval_line(int i, longint x);
      return slope_at(i) * x + icpt_at(i);
   endfunction

   function automatic int sign_of(longint v);
      return (v == 0) ? 0 : ((v < 0) ? -1 : 1);
   endfunction

   function automatic longint negate_sat(longint v);
      if (v == -64'sd2147483648) return 64'sd2147483647;
      return -v;
   endfunction

   function automatic bit middle_covered(longint a1, longint b1, longint a2, longint b2,
                                         longint a3, longint b3);
      logic signed [127:0] p, q, r, s;
      if (b2 == b1 || b3 == b2)
         return sign_of(a2 - a1) * sign_of(b3 - b2) >= sign_of(a3 - a2) * sign_of(b2 - b1);
      p = a2 - a1;
      q = b3 - b2;
      r = b2 - b1;
      s = a3 - a2;
      return (p * q) >= (r * s);
   endfunction

   function automatic void put_line(int pos, longint a, longint b);
      hull_lines[pos].slope     = a[31:0];
      hull_lines[pos].intercept = b[31:0];
   endfunction

   function automatic logic [1:0] insert_line(longint a, longint b);
      if (line_total == 0) begin
         front_pos = (front_pos + HULL_DEPTH - 1) % HULL_DEPTH;
         put_line(front_pos, a, b);
         line_total++;
         return ST_OK;
      end
      if (!(a <= slope_at(line_total - 1) || a >= slope_at(0))) return ST_ORDER;
      if (slope_at(0) <= a) begin
         if (slope_at(0) == a) begin
            if (icpt_at(0) <= b) return ST_OK;
            front_pos = (front_pos + 1) % HULL_DEPTH;
            line_total--;
         end
         if (line_total >= HULL_DEPTH) return ST_FULL;
         while (line_total >= 2 &&
                middle_covered(a, b, slope_at(0), icpt_at(0), slope_at(1), icpt_at(1))) begin
            front_pos = (front_pos + 1) % HULL_DEPTH;
            line_total--;
         end
         front_pos = (front_pos + HULL_DEPTH - 1) % HULL_DEPTH;
         put_line(front_pos, a, b);
         line_total++;
      end else begin
         if (slope_at(line_total - 1) == a) begin
            if (icpt_at(line_total - 1) <= b) return ST_OK;
            line_total--;
         end
         if (line_total >= HULL_DEPTH) return ST_FULL;
         while (line_total >= 2 &&
                middle_covered(slope_at(line_total - 2), icpt_at(line_total - 2),
                               slope_at(line_total - 1), icpt_at(line_total - 1), a, b))
            line_total--;
         put_line(slot_of(line_total), a, b);
         line_total++;
      end
      return ST_OK;
   endfunction

   function automatic logic signed [62:0] clamp_value(longint y);
      longint lim;
      lim = 64'sd1 <<< 62;
      if (!minimize) y = -y;
      if (y >= lim) y = lim - 1;
      if (y < -lim) y = -lim;
      return y[62:0];
   endfunction

   function automatic outcome_type predict_outcome(logic [2:0] func, longint a, longint b,
                                                   longint x);
      outcome_type res;
      int          lo, hi, mid;
      res.value  = '0;
      res.status = ST_OK;
      if (func == FUNC_ADD) begin
         if (!minimize) begin
            a = negate_sat(a);
            b = negate_sat(b);
         end
         res.status = insert_line(a, b);
      end else if (func == FUNC_QUERY || func == FUNC_INC || func == FUNC_DEC) begin
         if (line_total == 0) begin
            res.status = ST_EMPTY;
         end else if (func == FUNC_QUERY) begin
            lo = -1;
            hi = line_total - 1;
            while (lo + 1 < hi) begin
               mid = lo + (hi - lo) / 2;
               if (eval_line(mid, x) >= eval_line(mid + 1, x)) lo = mid;
               else hi = mid;
            end
            res.value = clamp_value(eval_line(hi, x));
         end else if (func == FUNC_INC) begin
            while (line_total >= 2 && eval_line(0, x) >= eval_line(1, x)) begin
               front_pos = (front_pos + 1) % HULL_DEPTH;
               line_total--;
            end
            res.value = clamp_value(eval_line(0, x));
         end else begin
            while (line_total >= 2 &&
                   eval_line(line_total - 1, x) >= eval_line(line_total - 2, x))
               line_total--;
            res.value = clamp_value(eval_line(line_total - 1, x));
         end
      end else if (func == FUNC_CLEAR) begin
         line_total = 0;
         front_pos  = 0;
      end
      return res;
   endfunction

   assign pending_count = expected_outcomes.size();

   always @(posedge clock) begin
      outcome_type want;
      int          errs;
      errs = 0;
      if (reset) begin
         front_pos  = 0;
         line_total = 0;
         minimize   = 1'b1;
         expected_outcomes.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) minimize = csr_wdata[0];
         if (req_valid && req_ready)
            expected_outcomes.push_back(predict_outcome(req_func, req_slope,
                                                        req_intercept, req_x_point));
         if (rsp_valid && rsp_ready) begin
            if (expected_outcomes.size() == 0) begin
               $error("response transaction with nothing expected");
               errs++;
            end else begin
               want = expected_outcomes[0];
               expected_outcomes.delete(0);
               if (rsp_value !== want.value) begin
                  $error("value: expected %0d, actual %0d", want.value, rsp_value);
                  errs++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

>>> tb/tb.sv
// Testbench top for the hull unit: clock, reset, stimulus and the final verdict.
`timescale 1ns / 100ps
module tb;
   import mchtu_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [2:0]         req_func;
   logic signed [31:0] req_slope;
   logic signed [31:0] req_intercept;
   logic signed [31:0] req_x_point;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [62:0] rsp_value;
   logic [1:0]         rsp_status;
   logic               csr_we;
   logic [0:0]         csr_wdata;
   int                 fail_count;
   int                 pending_count;
   bit                 calm;
   longint             top_slope;
   longint             low_slope;
   bit                 have_lines;

   monotone_convex_hull_trick_unit dut (.*);

   mchtu_scoreboard u_scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) rsp_ready <= calm || ($urandom_range(0, 99) >= 12);

   task automatic send(logic [2:0] func, longint a, longint b, longint x);
      if (!calm && $urandom_range(0, 99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= func;
      req_slope     <= a[31:0];
      req_intercept <= b[31:0];
      req_x_point   <= x[31:0];
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_mode(logic mode);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic longint rand32();
      return longint'($signed($urandom()));
   endfunction

   function automatic longint clip(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483647) return -64'sd2147483647;
      return v;
   endfunction

   task automatic random_op();
      int     pick;
      longint s;
      longint x;
      pick = $urandom_range(0, 99);
      x = ($urandom_range(0, 1) == 1) ? rand32() : longint'($urandom_range(0, 4000)) - 2000;
      if (pick < 50) begin
         if (!have_lines) begin
            s = ($urandom_range(0, 3) == 0) ? rand32() : longint'($urandom_range(0, 2000)) - 1000;
            top_slope = s;
            low_slope = s;
            have_lines = 1'b1;
         end else if ($urandom_range(0, 1) == 1) begin
            s = clip(top_slope + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1000)));
            top_slope = s;
         end else begin
            s = clip(low_slope - (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1000)));
            low_slope = s;
         end
         send(FUNC_ADD, s, rand32(), rand32());
      end else if (pick < 65) send(FUNC_QUERY, rand32(), rand32(), x);
      else if (pick < 75) send(FUNC_INC, rand32(), rand32(), x);
      else if (pick < 85) send(FUNC_DEC, rand32(), rand32(), x);
      else if (pick < 90) begin
         s = (top_slope - low_slope >= 2) ? low_slope + 1 : rand32();
         send(FUNC_ADD, s, rand32(), x);
      end else if (pick < 93) send(3'($urandom_range(5, 7)), rand32(), rand32(), x);
      else begin
         send(FUNC_CLEAR, rand32(), rand32(), x);
         have_lines = 1'b0;
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = FUNC_CLEAR;
      req_slope     = '0;
      req_intercept = '0;
      req_x_point   = '0;
      csr_we        = 1'b0;
      csr_wdata     = 1'b1;
      calm          = 1'b0;
      have_lines    = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_mode(1'b1);
      send(FUNC_QUERY, 0, 0, 5);
      send(FUNC_INC, 0, 0, 5);
      send(FUNC_DEC, 0, 0, 5);
      send(FUNC_ADD, 64'sd2147483647, 64'sd2147483647, 0);
      send(FUNC_ADD, -64'sd2147483648, 64'sd2147483647, 0);
      send(FUNC_ADD, 0, -64'sd2147483647, 0);
      send(FUNC_ADD, 0, 100, 0);
      send(FUNC_ADD, 64'sd2147483647, -64'sd2147483648, 0);
      send(FUNC_QUERY, 0, 0, -64'sd2147483648);
      send(FUNC_QUERY, 0, 0, 64'sd2147483647);
      send(FUNC_INC, 0, 0, -64'sd2147483647);
      send(FUNC_DEC, 0, 0, 64'sd2147483647);
      send(3'd5, 0, 0, 0);
      send(3'd7, -1, -1, -1);
      send(FUNC_CLEAR, 0, 0, 0);
      send(FUNC_ADD, 10, 0, 0);
      send(FUNC_ADD, -10, 0, 0);
      send(FUNC_ADD, 0, 5, 0);
      send(FUNC_ADD, 0, -5, 0);
      send(FUNC_QUERY, 0, 0, 1);
      send(FUNC_CLEAR, 0, 0, 0);

      write_mode(1'b0);
      send(FUNC_ADD, -64'sd2147483648, -64'sd2147483648, 0);
      send(FUNC_ADD, 64'sd2147483647, 0, 0);
      send(FUNC_QUERY, 0, 0, -64'sd2147483648);
      send(FUNC_QUERY, 0, 0, 64'sd2147483647);
      send(FUNC_CLEAR, 0, 0, 0);

      for (int phase = 0; phase < 3; phase++) begin
         write_mode(phase != 1);
         send(FUNC_CLEAR, 0, 0, 0);
         have_lines = 1'b0;
         for (int n = 0; n < 290; n++) begin
            calm = (phase == 1 && n >= 100 && n < 220);
            random_op();
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
